>>> rtl/prq_pkg.sv
package prq_pkg;

   // Sizes of the task table and of the level table
   localparam int NUM_TASKS  = 16;
   localparam int NUM_LEVELS = 16;

   // Field widths
   localparam int OPCODE_W = 2;
   localparam int INDEX_W  = 5;
   localparam int TASK_W   = 4;
   localparam int LEVEL_W  = 4;
   localparam int STATUS_W = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_PEEK    = 2'd2,
      OP_PEEK_ALT = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_DUPLICATE = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic execute;
   } cmd_type;

endpackage

>>> rtl/prq_if.sv
interface prq_req_if;
   logic                          valid;
   logic                          ready;
   logic [prq_pkg::OPCODE_W-1:0]  opcode;
   logic [prq_pkg::INDEX_W-1:0]   task_index;
   logic [prq_pkg::LEVEL_W-1:0]   task_level;

   modport source (output valid, output opcode, output task_index, output task_level,
                   input ready);
   modport sink   (input valid, input opcode, input task_index, input task_level,
                   output ready);
endinterface

interface prq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [prq_pkg::TASK_W-1:0]    chosen_task;
   logic [prq_pkg::LEVEL_W-1:0]   chosen_level;
   logic                          found;
   logic [prq_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output chosen_task, output chosen_level, output found,
                   output status, input ready);
   modport sink   (input valid, input chosen_task, input chosen_level, input found,
                   input status, output ready);
endinterface

>>> rtl/prq_ctrl.sv
module prq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output prq_pkg::cmd_type  cmd
);

   prq_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // Output register can take a new result when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.load_req = 1'b0;
      cmd.execute  = 1'b0;
      unique case (state_ff)
         prq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = prq_pkg::ST_EXEC;
            end
         end
         prq_pkg::ST_EXEC: begin
            if (out_free) begin
               cmd.execute = 1'b1;
               state_in    = prq_pkg::ST_IDLE;
            end
         end
         default: state_in = prq_pkg::ST_IDLE;
      endcase
   end

   // Response valid flag
   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/prq_datapath.sv
module prq_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  prq_pkg::cmd_type              cmd,
   input  logic [prq_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [prq_pkg::INDEX_W-1:0]   req_task_index,
   input  logic [prq_pkg::LEVEL_W-1:0]   req_task_level,
   output logic [prq_pkg::TASK_W-1:0]    rsp_chosen_task,
   output logic [prq_pkg::LEVEL_W-1:0]   rsp_chosen_level,
   output logic                          rsp_found,
   output logic [prq_pkg::STATUS_W-1:0]  rsp_status
);

   // Registered request
   prq_pkg::opcode_type                op_ff;
   logic [prq_pkg::INDEX_W-1:0]        index_ff;
   logic [prq_pkg::LEVEL_W-1:0]        level_ff;

   // Queue state: per-level head/tail ids, per-task link, level and flags
   logic [prq_pkg::TASK_W-1:0]         head_ff [prq_pkg::NUM_LEVELS];
   logic [prq_pkg::TASK_W-1:0]         tail_ff [prq_pkg::NUM_LEVELS];
   logic [prq_pkg::TASK_W-1:0]         next_ff [prq_pkg::NUM_TASKS];
   logic [prq_pkg::LEVEL_W-1:0]        prio_ff [prq_pkg::NUM_TASKS];
   logic [prq_pkg::NUM_LEVELS-1:0]     busy_ff;
   logic [prq_pkg::NUM_TASKS-1:0]      queued_ff;
   logic [prq_pkg::NUM_TASKS-1:0]      has_next_ff;

   // Result register
   logic [prq_pkg::TASK_W-1:0]         out_task_ff,  out_task_in;
   logic [prq_pkg::LEVEL_W-1:0]        out_level_ff, out_level_in;
   logic                               out_found_ff, out_found_in;
   prq_pkg::status_type                out_status_ff, out_status_in;

   logic [prq_pkg::LEVEL_W-1:0]        top_lv;
   logic                               any_busy;
   logic [prq_pkg::TASK_W-1:0]         head_t;
   logic [prq_pkg::TASK_W-1:0]         enq_t;
   logic [prq_pkg::LEVEL_W-1:0]        enq_lv;
   logic [prq_pkg::TASK_W-1:0]         tail_t;
   logic                               in_range;
   logic                               do_enq;
   logic                               do_deq;

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= prq_pkg::opcode_type'(req_opcode);
         index_ff <= req_task_index;
         level_ff <= req_task_level;
      end
   end

   // Priority encoder: lowest-numbered non-empty level
   always_comb begin
      top_lv = '0;
      for (int i = prq_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
         if (busy_ff[i]) begin
            top_lv = prq_pkg::LEVEL_W'(i);
         end
      end
   end

   assign any_busy = |busy_ff;
   assign head_t   = head_ff[top_lv];
   assign enq_t    = index_ff[prq_pkg::TASK_W-1:0];
   assign in_range = index_ff < prq_pkg::INDEX_W'(prq_pkg::NUM_TASKS);
   // Saturate the enqueue level to the last level
   assign enq_lv   = ({1'b0, level_ff} >= (prq_pkg::LEVEL_W + 1)'(prq_pkg::NUM_LEVELS)) ?
                     prq_pkg::LEVEL_W'(prq_pkg::NUM_LEVELS - 1) : level_ff;
   assign tail_t   = tail_ff[enq_lv];

   // Result and update decisions
   always_comb begin
      out_task_in   = '0;
      out_level_in  = '0;
      out_found_in  = 1'b0;
      out_status_in = prq_pkg::STATUS_OK;
      do_enq        = 1'b0;
      do_deq        = 1'b0;
      if (op_ff == prq_pkg::OP_ENQUEUE) begin
         if (!in_range) begin
            out_status_in = prq_pkg::STATUS_RANGE;
         end else if (queued_ff[enq_t]) begin
            out_task_in   = enq_t;
            out_level_in  = prio_ff[enq_t];
            out_status_in = prq_pkg::STATUS_DUPLICATE;
         end else begin
            out_task_in  = enq_t;
            out_level_in = enq_lv;
            out_found_in = 1'b1;
            do_enq       = 1'b1;
         end
      end else begin
         if (!any_busy) begin
            out_status_in = prq_pkg::STATUS_EMPTY;
         end else begin
            out_task_in  = head_t;
            out_level_in = top_lv;
            out_found_in = 1'b1;
            do_deq       = (op_ff == prq_pkg::OP_DEQUEUE);
         end
      end
   end

   // Result register and queue payload
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         out_task_ff   <= out_task_in;
         out_level_ff  <= out_level_in;
         out_found_ff  <= out_found_in;
         out_status_ff <= out_status_in;
         if (do_enq) begin
            prio_ff[enq_t]  <= enq_lv;
            tail_ff[enq_lv] <= enq_t;
            if (busy_ff[enq_lv]) begin
               next_ff[tail_t] <= enq_t;
            end else begin
               head_ff[enq_lv] <= enq_t;
            end
         end
         if (do_deq && has_next_ff[head_t]) begin
            head_ff[top_lv] <= next_ff[head_t];
         end
      end
   end

   // Occupancy flags
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= '0;
         queued_ff   <= '0;
         has_next_ff <= '0;
      end else if (cmd.execute) begin
         if (do_enq) begin
            queued_ff[enq_t]   <= 1'b1;
            has_next_ff[enq_t] <= 1'b0;
            busy_ff[enq_lv]    <= 1'b1;
            if (busy_ff[enq_lv]) begin
               has_next_ff[tail_t] <= 1'b1;
            end
         end
         if (do_deq) begin
            queued_ff[head_t]   <= 1'b0;
            has_next_ff[head_t] <= 1'b0;
            if (!has_next_ff[head_t]) begin
               busy_ff[top_lv] <= 1'b0;
            end
         end
      end
   end

   assign rsp_chosen_task  = out_task_ff;
   assign rsp_chosen_level = out_level_ff;
   assign rsp_found        = out_found_ff;
   assign rsp_status       = out_status_ff;

endmodule

>>> rtl/priority_ready_queue_scheduler_top.sv
// Channel  Dir  Handshake    Payload
// req      in   valid/ready  opcode, task_index, task_level
// rsp      out  valid/ready  chosen_task, chosen_level, found, status
//
// Each request is captured in the idle state; the execute state then runs the level
// priority encoder and updates the head/tail/link tables.
// A new request is taken while the previous result waits in the output register;
// execution holds only when that register is still full.
// Synchronous reset empties every level and clears all queued flags at once.
module priority_ready_queue_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   prq_req_if.sink     req,
   prq_rsp_if.source   rsp
);

   prq_pkg::cmd_type cmd;

   prq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   prq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_opcode       (req.opcode),
      .req_task_index   (req.task_index),
      .req_task_level   (req.task_level),
      .rsp_chosen_task  (rsp.chosen_task),
      .rsp_chosen_level (rsp.chosen_level),
      .rsp_found        (rsp.found),
      .rsp_status       (rsp.status)
   );

   // An executed request always leaves a result behind
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp.valid)
      else $error("executed request produced no response");

   // Only one request in flight between capture and execution
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request accepted while another is pending");

   // found is set exactly for successful results
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.found == (rsp.status == prq_pkg::STATUS_OK)))
      else $error("found flag disagrees with status");

   // Empty and out-of-range results carry a zero task and level
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.status == prq_pkg::STATUS_EMPTY ||
                     rsp.status == prq_pkg::STATUS_RANGE))
      |-> (rsp.chosen_task == '0 && rsp.chosen_level == '0))
      else $error("error result with nonzero task or level");

endmodule

>>> test/priority_ready_queue_scheduler_top_test.sv
module priority_ready_queue_scheduler_top_test;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_PER_PHASE = 510;

   // One scheduler outcome as seen on the result channel
   typedef struct packed {
      logic [prq_pkg::TASK_W-1:0]  tid;
      logic [prq_pkg::LEVEL_W-1:0] level;
      logic                        found;
      prq_pkg::status_type         status;
   } sched_result_type;

   logic clock;
   logic reset;

   prq_req_if req_ch ();
   prq_rsp_if rsp_ch ();

   priority_ready_queue_scheduler_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Shadow copy of the ready queue tables
   bit                        head_valid [prq_pkg::NUM_LEVELS];
   bit [prq_pkg::TASK_W-1:0]  head_id    [prq_pkg::NUM_LEVELS];
   bit                        tail_valid [prq_pkg::NUM_LEVELS];
   bit [prq_pkg::TASK_W-1:0]  tail_id    [prq_pkg::NUM_LEVELS];
   bit                        link_valid [prq_pkg::NUM_TASKS];
   bit [prq_pkg::TASK_W-1:0]  link_id    [prq_pkg::NUM_TASKS];
   bit [prq_pkg::LEVEL_W-1:0] task_prio  [prq_pkg::NUM_TASKS];
   bit                        task_ready [prq_pkg::NUM_TASKS];

   sched_result_type pending_outcomes[$];

   int error_count = 0;
   int send_idle_pct = 33;
   int recv_idle_pct = 60;
   int stall_cycles = 0;

   // Clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   task automatic report_failure(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   task automatic clear_schedule_model();
      for (int i = 0; i < prq_pkg::NUM_LEVELS; i++) begin
         head_valid[i] = 1'b0;
         head_id[i] = '0;
         tail_valid[i] = 1'b0;
         tail_id[i] = '0;
      end
      for (int i = 0; i < prq_pkg::NUM_TASKS; i++) begin
         link_valid[i] = 1'b0;
         link_id[i] = '0;
         task_prio[i] = '0;
         task_ready[i] = 1'b0;
      end
   endtask

   // Apply one request to the shadow tables and return its outcome
   function automatic sched_result_type schedule_outcome(
         input prq_pkg::opcode_type op,
         input logic [prq_pkg::INDEX_W-1:0] idx,
         input logic [prq_pkg::LEVEL_W-1:0] lvl);
      sched_result_type res;
      logic [prq_pkg::TASK_W-1:0] t;
      int l;
      int top;
      res = '{tid: '0, level: '0, found: 1'b0, status: prq_pkg::STATUS_OK};
      if (op == prq_pkg::OP_ENQUEUE) begin
         t = idx[prq_pkg::TASK_W-1:0];
         if (idx >= prq_pkg::NUM_TASKS) begin
            res.status = prq_pkg::STATUS_RANGE;
         end else if (task_ready[t]) begin
            res.tid = t;
            res.level = task_prio[t];
            res.status = prq_pkg::STATUS_DUPLICATE;
         end else begin
            l = (lvl >= prq_pkg::NUM_LEVELS) ? prq_pkg::NUM_LEVELS - 1 : int'(lvl);
            task_prio[t] = l[prq_pkg::LEVEL_W-1:0];
            link_valid[t] = 1'b0;
            task_ready[t] = 1'b1;
            // append at the tail of the level FIFO
            if (tail_valid[l]) begin
               link_valid[tail_id[l]] = 1'b1;
               link_id[tail_id[l]] = t;
            end else begin
               head_valid[l] = 1'b1;
               head_id[l] = t;
            end
            tail_valid[l] = 1'b1;
            tail_id[l] = t;
            res.tid = t;
            res.level = l[prq_pkg::LEVEL_W-1:0];
            res.found = 1'b1;
         end
      end else begin
         // lowest-numbered non-empty level wins
         top = -1;
         for (int i = prq_pkg::NUM_LEVELS - 1; i >= 0; i--)
            if (head_valid[i]) top = i;
         if (top < 0) begin
            res.status = prq_pkg::STATUS_EMPTY;
         end else begin
            t = head_id[top];
            if (op == prq_pkg::OP_DEQUEUE) begin
               head_valid[top] = link_valid[t];
               head_id[top] = link_id[t];
               if (!link_valid[t]) tail_valid[top] = 1'b0;
               link_valid[t] = 1'b0;
               task_ready[t] = 1'b0;
            end
            res.tid = t;
            res.level = top[prq_pkg::LEVEL_W-1:0];
            res.found = 1'b1;
         end
      end
      return res;
   endfunction

   // Send one request, with an optional idle gap before it
   task automatic send_request(input prq_pkg::opcode_type op,
                               input logic [prq_pkg::INDEX_W-1:0] idx,
                               input logic [prq_pkg::LEVEL_W-1:0] lvl);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.task_index <= idx;
      req_ch.task_level <= lvl;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_outcomes.push_back(schedule_outcome(op, idx, lvl));
   endtask

   // Result checker and receiver stalls
   always @(posedge clock) begin : rsp_monitor
      sched_result_type want;
      sched_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.tid = rsp_ch.chosen_task;
         got.level = rsp_ch.chosen_level;
         got.found = rsp_ch.found;
         got.status = prq_pkg::status_type'(rsp_ch.status);
         if (pending_outcomes.size() == 0) begin
            report_failure($sformatf("result with nothing expected: task %0d level %0d",
                                     got.tid, got.level));
         end else begin
            want = pending_outcomes.pop_front();
            if (got.tid !== want.tid)
               report_failure($sformatf("chosen_task %0d, expected %0d", got.tid, want.tid));
            if (got.level !== want.level)
               report_failure($sformatf("chosen_level %0d, expected %0d",
                                        got.level, want.level));
            if (got.found !== want.found)
               report_failure($sformatf("found %0b, expected %0b", got.found, want.found));
            if (got.status !== want.status)
               report_failure($sformatf("status %0d, expected %0d",
                                        got.status, want.status));
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Peek and dequeue with every level empty, plus the alternate peek opcode
   task automatic test_empty_queue();
      send_request(prq_pkg::OP_PEEK, 5'd0, 4'd0);
      send_request(prq_pkg::OP_DEQUEUE, 5'd31, 4'd15);
      send_request(prq_pkg::OP_PEEK_ALT, 5'd0, 4'd0);
   endtask

   // Ids past the task table
   task automatic test_bad_index();
      send_request(prq_pkg::OP_ENQUEUE, 5'd16, 4'd15);
      send_request(prq_pkg::OP_ENQUEUE, 5'd31, 4'd0);
   endtask

   // Order across levels and first-in first-out within a level
   task automatic test_fifo_order();
      send_request(prq_pkg::OP_ENQUEUE, 5'd15, 4'd15);
      send_request(prq_pkg::OP_ENQUEUE, 5'd3, 4'd5);
      send_request(prq_pkg::OP_ENQUEUE, 5'd7, 4'd5);
      send_request(prq_pkg::OP_ENQUEUE, 5'd0, 4'd0);
      send_request(prq_pkg::OP_ENQUEUE, 5'd9, 4'd5);
      send_request(prq_pkg::OP_PEEK, 5'd0, 4'd0);
      repeat (4) send_request(prq_pkg::OP_DEQUEUE, 5'd0, 4'd0);
      send_request(prq_pkg::OP_PEEK_ALT, 5'd0, 4'd0);
      send_request(prq_pkg::OP_DEQUEUE, 5'd0, 4'd0);
      send_request(prq_pkg::OP_DEQUEUE, 5'd0, 4'd0);
   endtask

   // Enqueue of a task already queued, then again once it left
   task automatic test_duplicate_enqueue();
      send_request(prq_pkg::OP_ENQUEUE, 5'd4, 4'd2);
      send_request(prq_pkg::OP_ENQUEUE, 5'd4, 4'd9);
      send_request(prq_pkg::OP_DEQUEUE, 5'd0, 4'd0);
      send_request(prq_pkg::OP_ENQUEUE, 5'd4, 4'd9);
      send_request(prq_pkg::OP_DEQUEUE, 5'd0, 4'd0);
   endtask

   // Mixed traffic; the enqueue share swings so the queue fills and drains
   task automatic test_random_traffic(input int count);
      int fill_pct;
      int r;
      logic [prq_pkg::INDEX_W-1:0] idx;
      logic [prq_pkg::LEVEL_W-1:0] lvl;
      fill_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0) begin
            case ($urandom_range(2))
               0: fill_pct = 85;
               1: fill_pct = 50;
               default: fill_pct = 20;
            endcase
         end
         r = $urandom_range(99);
         lvl = ($urandom_range(3) == 0) ?
               prq_pkg::LEVEL_W'($urandom_range(prq_pkg::NUM_LEVELS - 1)) :
               prq_pkg::LEVEL_W'($urandom_range(3));
         if (r < 6) begin
            // out-of-range id
            idx = prq_pkg::INDEX_W'($urandom_range(31, prq_pkg::NUM_TASKS));
            send_request(prq_pkg::OP_ENQUEUE, idx, prq_pkg::LEVEL_W'($urandom));
         end else if (r < fill_pct) begin
            idx = prq_pkg::INDEX_W'($urandom_range(prq_pkg::NUM_TASKS - 1));
            send_request(prq_pkg::OP_ENQUEUE, idx, lvl);
         end else if ($urandom_range(3) != 0) begin
            send_request(prq_pkg::OP_DEQUEUE, prq_pkg::INDEX_W'($urandom),
                         prq_pkg::LEVEL_W'($urandom));
         end else begin
            send_request($urandom_range(1) ? prq_pkg::OP_PEEK : prq_pkg::OP_PEEK_ALT,
                         prq_pkg::INDEX_W'($urandom), prq_pkg::LEVEL_W'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.opcode = prq_pkg::OP_ENQUEUE;
      req_ch.task_index = '0;
      req_ch.task_level = '0;
      clear_schedule_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // sender idles less than the receiver
      send_idle_pct = 33;
      recv_idle_pct = 60;
      test_empty_queue();
      test_bad_index();
      test_fifo_order();
      test_duplicate_enqueue();
      test_random_traffic(RANDOM_PER_PHASE);

      // receiver idles less than the sender
      send_idle_pct = 60;
      recv_idle_pct = 33;
      test_random_traffic(RANDOM_PER_PHASE);

      // back to back
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(RANDOM_PER_PHASE);

      @(posedge clock);
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
